// ===== rtl/eld_pkg.sv =====
package eld_pkg;

    localparam int ByteW   = 8;
    localparam int LenW    = 16;

    // configuration register indexes
    localparam int CfgIdxW = 1;
    localparam logic [CfgIdxW-1:0] CfgStart  = 1'b0;
    localparam logic [CfgIdxW-1:0] CfgEscape = 1'b1;

    localparam logic [ByteW-1:0] StartReset  = 8'd60;
    localparam logic [ByteW-1:0] EscapeReset = 8'd62;

    // input-side word queue
    localparam int InDepth = 4;
    localparam int InAw    = 2;
    localparam int InCntW  = 3;

    // result queue
    localparam int ResDepth = 4;
    localparam int ResAw    = 2;
    localparam int ResCntW  = 3;

    typedef struct packed {
        logic [ByteW-1:0] data;
        logic             is_start;
        logic             is_esc;
    } t_word;

    typedef struct packed {
        logic  valid;
        t_word word;
    } t_src;

    typedef struct packed {
        logic [ByteW-1:0] payload_byte;
        logic             last;
        logic             empty_frame;
    } t_result;

    typedef enum logic [3:0] {
        PhIdle    = 4'b0001,
        PhLenHi   = 4'b0010,
        PhLenLo   = 4'b0100,
        PhPayload = 4'b1000
    } t_phase;

endpackage

// ===== rtl/eld_front.sv =====
module eld_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [eld_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [eld_pkg::ByteW-1:0]   i_cfg_data,
    input  logic                        i_push,
    input  logic [eld_pkg::ByteW-1:0]   i_rx_byte,
    output logic                        o_full,
    input  logic                        i_take,
    output eld_pkg::t_src               o_src
);
    import eld_pkg::*;

    logic [ByteW-1:0]  r_start_byte;
    logic [ByteW-1:0]  r_escape_byte;
    t_word             r_mem [InDepth];
    logic [InAw-1:0]   r_wr_ptr;
    logic [InAw-1:0]   r_rd_ptr;
    logic [InCntW-1:0] r_cnt;
    logic [InCntW-1:0] n_cnt;
    logic              push;
    logic              pop;
    t_word             new_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte  <= StartReset;
            r_escape_byte <= EscapeReset;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CfgStart:  r_start_byte  <= i_cfg_data;
                CfgEscape: r_escape_byte <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // start wins when both markers hold the same value
    always_comb begin
        new_word.data     = i_rx_byte;
        new_word.is_start = (i_rx_byte == r_start_byte);
        new_word.is_esc   = (i_rx_byte == r_escape_byte);
    end

    assign o_full = (r_cnt == InCntW'(InDepth));
    assign push   = i_push && !o_full;
    assign pop    = i_take && (r_cnt != '0);

    always_comb begin
        case ({push, pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr_ptr] <= new_word;
    end

    assign o_src.valid = (r_cnt != '0);
    assign o_src.word  = r_mem[r_rd_ptr];

endmodule

// ===== rtl/eld_back.sv =====
module eld_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  eld_pkg::t_src             i_src,
    output logic                      o_take,
    output logic                      o_empty,
    input  logic                      i_pop,
    output logic [eld_pkg::ByteW-1:0] o_payload_byte,
    output logic                      o_last,
    output logic                      o_empty_frame
);
    import eld_pkg::*;

    t_phase             r_phase;
    t_phase             n_phase;
    logic [ByteW-1:0]   r_offset;
    logic [ByteW-1:0]   n_offset;
    logic [LenW-1:0]    r_length;
    logic [LenW-1:0]    n_length;
    logic [LenW-1:0]    r_count;
    logic [LenW-1:0]    n_count;

    t_result            r_res [ResDepth];
    logic [ResAw-1:0]   r_wr_ptr;
    logic [ResAw-1:0]   r_rd_ptr;
    logic [ResCntW-1:0] r_cnt;
    logic [ResCntW-1:0] n_cnt;

    logic               res_full;
    logic               res_push;
    logic               res_pop;
    logic               res_valid;
    t_result            res;
    logic [ByteW:0]     sum;
    logic               has_data;
    logic [LenW-1:0]    count_after;

    assign res_full = (r_cnt == ResCntW'(ResDepth));
    assign o_take   = i_src.valid && !res_full;
    assign sum      = {1'b0, i_src.word.data} + {1'b0, r_offset};
    assign has_data = (r_count < r_length);
    assign count_after = has_data ? r_count + 1'b1 : r_count;

    always_comb begin
        n_phase   = r_phase;
        n_offset  = r_offset;
        n_length  = r_length;
        n_count   = r_count;
        res_valid = 1'b0;
        res.payload_byte = '0;
        res.last         = 1'b0;
        res.empty_frame  = 1'b0;
        if (o_take) begin
            if (i_src.word.is_start) begin
                n_phase  = PhLenHi;
                n_offset = '0;
                n_length = '0;
                n_count  = '0;
            end else if (i_src.word.is_esc) begin
                // the escape byte's own value is the offset
                n_offset = i_src.word.data;
            end else begin
                case (r_phase)
                    PhLenHi: begin
                        n_length = {sum[ByteW-1:0], {ByteW{1'b0}}};
                        n_offset = '0;
                        n_phase  = PhLenLo;
                    end
                    PhLenLo: begin
                        n_length = r_length + LenW'(sum);
                        n_offset = '0;
                        n_phase  = PhPayload;
                    end
                    PhPayload: begin
                        res_valid        = 1'b1;
                        n_count          = count_after;
                        res.payload_byte = has_data ? sum[ByteW-1:0] : '0;
                        res.empty_frame  = !has_data;
                        res.last         = (count_after == r_length);
                        n_offset         = '0;
                        if (count_after == r_length) begin
                            n_length = '0;
                            n_count  = '0;
                            n_phase  = PhIdle;
                        end
                    end
                    default: ;  // idle: byte dropped, offset stays armed
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PhIdle;
            r_offset <= '0;
            r_length <= '0;
            r_count  <= '0;
        end else begin
            r_phase  <= n_phase;
            r_offset <= n_offset;
            r_length <= n_length;
            r_count  <= n_count;
        end
    end

    // result queue
    assign res_push = res_valid;
    assign res_pop  = i_pop && !o_empty;
    assign o_empty  = (r_cnt == '0);

    always_comb begin
        case ({res_push, res_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (res_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (res_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_push) r_res[r_wr_ptr] <= res;
    end

    assign o_payload_byte = r_res[r_rd_ptr].payload_byte;
    assign o_last         = r_res[r_rd_ptr].last;
    assign o_empty_frame  = r_res[r_rd_ptr].empty_frame;

    a_res_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= ResCntW'(ResDepth))
        else $error("result queue count overflow");

    a_count_le_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_length)
        else $error("payload count ran past frame length");

    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PhIdle) |-> (r_length == '0 && r_count == '0))
        else $error("frame state not cleared while idle");

    a_start_len_hi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && i_src.word.is_start) |=> (r_phase == PhLenHi && r_offset == '0))
        else $error("start marker did not restart the parser");

endmodule

// ===== rtl/escaped_length_prefixed_deframer.sv =====
// Channel   Direction  Handshake                       Payload
// input     in         i_push / o_full                 i_rx_byte
// result    out        o_empty / i_pop                 o_payload_byte, o_last, o_empty_frame
// config    in         i_cfg_wr_en (no wait)           i_cfg_index, i_cfg_data
//
// One word per cycle sustained while the result queue has room. A word is
// classified against the marker registers on entry and queued (4 deep); the
// parser takes one queued word a cycle unless the result queue is full, and
// writes results into a 4-deep result queue. A result shows on the result
// ports, at the soonest, after passing the input queue and the result queue.
// Reset is synchronous; queues empty, parser idle, markers at 60 and 62.
// A full result queue stalls the parser only; input keeps filling its queue
// and o_full rises once that queue holds 4 words too.
module escaped_length_prefixed_deframer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [eld_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [eld_pkg::ByteW-1:0]   i_cfg_data,
    input  logic                        i_push,
    output logic                        o_full,
    input  logic [eld_pkg::ByteW-1:0]   i_rx_byte,
    output logic                        o_empty,
    input  logic                        i_pop,
    output logic [eld_pkg::ByteW-1:0]   o_payload_byte,
    output logic                        o_last,
    output logic                        o_empty_frame
);
    import eld_pkg::*;

    t_src src;
    logic take;

    eld_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_push      (i_push),
        .i_rx_byte   (i_rx_byte),
        .o_full      (o_full),
        .i_take      (take),
        .o_src       (src)
    );

    eld_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_src          (src),
        .o_take         (take),
        .o_empty        (o_empty),
        .i_pop          (i_pop),
        .o_payload_byte (o_payload_byte),
        .o_last         (o_last),
        .o_empty_frame  (o_empty_frame)
    );

endmodule

// ===== sim/tb_escaped_length_prefixed_deframer.sv =====
`timescale 1ns / 1ps

module tb_escaped_length_prefixed_deframer;
    import eld_pkg::*;

    localparam int CycleLimit = 1000000;
    localparam int SettleCycles = 24;
    localparam int PhaseWords = 240;
    localparam int HoldCycles = 250;
    localparam int DirRows = 25;

    typedef struct packed {
        logic [ByteW-1:0] rx;
        logic             typed;
        logic             has_res;
        t_result          res;
    } t_row;

    localparam t_result NoRes = '0;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_wr_en = 1'b0;
    logic [CfgIdxW-1:0] i_cfg_index = CfgStart;
    logic [ByteW-1:0]   i_cfg_data = '0;
    logic               i_push = 1'b0;
    logic               o_full;
    logic [ByteW-1:0]   i_rx_byte = '0;
    logic               o_empty;
    logic               i_pop = 1'b0;
    logic [ByteW-1:0]   o_payload_byte;
    logic               o_last;
    logic               o_empty_frame;

    escaped_length_prefixed_deframer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_push         (i_push),
        .o_full         (o_full),
        .i_rx_byte      (i_rx_byte),
        .o_empty        (o_empty),
        .i_pop          (i_pop),
        .o_payload_byte (o_payload_byte),
        .o_last         (o_last),
        .o_empty_frame  (o_empty_frame)
    );

    always #5 i_clk = ~i_clk;

    // parser mirror
    logic [ByteW-1:0] start_reg = StartReset;
    logic [ByteW-1:0] esc_reg = EscapeReset;
    t_phase           ph = PhIdle;
    logic [ByteW-1:0] offset = '0;
    logic [LenW-1:0]  frame_len = '0;
    logic [LenW-1:0]  frame_cnt = '0;

    t_result due_results[$];
    int      mismatches = 0;
    int      cycles = 0;
    int      frame_words = 0;
    bit      burst = 1'b0;
    bit      hold_req = 1'b0;
    bit      hold_done = 1'b0;

    // directed rows, all with markers at reset values (start 60, escape 62)
    t_row dir_tab [DirRows] = '{
        '{8'h00, 1'b1, 1'b0, NoRes},               // idle, ignored
        '{8'hFF, 1'b1, 1'b0, NoRes},
        '{8'd60, 1'b1, 1'b0, NoRes},               // start
        '{8'h00, 1'b1, 1'b0, NoRes},
        '{8'h02, 1'b1, 1'b0, NoRes},               // length 2
        '{8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b0, 1'b0}},
        '{8'd62, 1'b1, 1'b0, NoRes},               // escape
        '{8'hC3, 1'b1, 1'b1, '{8'h01, 1'b1, 1'b0}}, // C3 + 3E wraps
        '{8'd60, 1'b1, 1'b0, NoRes},
        '{8'h00, 1'b1, 1'b0, NoRes},
        '{8'h00, 1'b1, 1'b0, NoRes},               // zero length
        '{8'hAA, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1}},
        '{8'd62, 1'b1, 1'b0, NoRes},               // escape while idle stays armed
        '{8'h55, 1'b1, 1'b0, NoRes},
        '{8'd60, 1'b1, 1'b0, NoRes},               // start clears it
        '{8'd62, 1'b1, 1'b0, NoRes},
        '{8'd62, 1'b1, 1'b0, NoRes},               // re-armed, not summed
        '{8'hC2, 1'b1, 1'b0, NoRes},               // high byte wraps to 0
        '{8'h01, 1'b1, 1'b0, NoRes},
        '{8'h80, 1'b1, 1'b1, '{8'h80, 1'b1, 1'b0}},
        '{8'd60, 1'b1, 1'b0, NoRes},
        '{8'h00, 1'b1, 1'b0, NoRes},
        '{8'h03, 1'b1, 1'b0, NoRes},
        '{8'd62, 1'b0, 1'b0, NoRes},
        '{8'h10, 1'b0, 1'b0, NoRes}
    };

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic void clear_frame();
        offset = '0;
        frame_len = '0;
        frame_cnt = '0;
    endfunction

    function automatic void deframe_byte(input logic [ByteW-1:0] b, output logic has,
                                         output t_result r);
        logic [ByteW:0] sum;
        sum = {1'b0, b} + {1'b0, offset};
        has = 1'b0;
        r = '0;
        if (b == start_reg) begin
            clear_frame();
            ph = PhLenHi;
        end else if (b == esc_reg) begin
            offset = esc_reg;
        end else begin
            case (ph)
                PhLenHi: begin
                    frame_len = {sum[ByteW-1:0], 8'h00};
                    offset = '0;
                    ph = PhLenLo;
                end
                PhLenLo: begin
                    frame_len = frame_len + LenW'(sum);
                    offset = '0;
                    ph = PhPayload;
                end
                PhPayload: begin
                    has = 1'b1;
                    if (frame_cnt < frame_len) begin
                        frame_cnt = frame_cnt + 1'b1;
                        r.payload_byte = sum[ByteW-1:0];
                    end else begin
                        r.empty_frame = 1'b1;
                    end
                    if (frame_cnt == frame_len) begin
                        r.last = 1'b1;
                        clear_frame();
                        ph = PhIdle;
                    end else begin
                        offset = '0;
                    end
                end
                default: ;
            endcase
        end
    endfunction

    task automatic offer(input logic [ByteW-1:0] b);
        @(negedge i_clk);
        i_push <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
    endtask

    task automatic idle_gap();
        int n;
        n = burst ? 0 : rand_gap();
        if (n > 0) begin
            @(negedge i_clk);
            i_push <= 1'b0;
            i_rx_byte <= 8'($urandom);
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_word(input logic [ByteW-1:0] b);
        logic    has;
        t_result r;
        if (!(ph == PhIdle && b != start_reg && b != esc_reg)) frame_words++;
        if (frame_words >= 200 && !hold_done) begin
            hold_req = 1'b1;
            hold_done = 1'b1;
        end
        offer(b);
        deframe_byte(b, has, r);
        if (has) due_results.push_back(r);
        idle_gap();
    endtask

    // send value v as data, escaping it when it collides with a marker (v is stepped up where no escape works)
    task automatic send_coded(input logic [ByteW-1:0] v);
        logic [ByteW-1:0] t;
        t = v - esc_reg;
        while ((v == start_reg || v == esc_reg) &&
               (start_reg == esc_reg || t == start_reg || t == esc_reg)) begin
            v = v + 8'd1;
            t = v - esc_reg;
        end
        if (v == start_reg || v == esc_reg) begin
            send_word(esc_reg);
            send_word(t);
        end else begin
            send_word(v);
        end
    endtask

    task automatic send_frame();
        int cap;
        int sent;
        burst = ($urandom_range(0, 4) == 0);
        send_word(start_reg);
        send_coded(($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'h00);
        send_coded(($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 24)));
        // some frames are cut short by the next start
        cap = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 6) : 300;
        sent = 0;
        while (ph == PhPayload && sent < cap) begin
            if (start_reg != esc_reg && $urandom_range(0, 9) == 0) send_word(esc_reg);
            send_coded(8'($urandom));
            sent++;
        end
    endtask

    task automatic send_noise();
        int n;
        int r;
        burst = ($urandom_range(0, 3) == 0);
        n = $urandom_range(1, 4);
        repeat (n) begin
            r = $urandom_range(0, 9);
            if (r < 2) send_word(start_reg);
            else if (r < 4) send_word(esc_reg);
            else send_word(8'($urandom));
        end
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_push <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] v);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == CfgStart) start_reg = v;
        else esc_reg = v;
    endtask

    // receiver: random stalls, calm stretches, one long hold-off on request
    initial begin
        int stall;
        int hold_left;
        int mode_left;
        bit calm;
        stall = 0;
        hold_left = 0;
        mode_left = 0;
        calm = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HoldCycles;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_pop <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                i_pop <= 1'b0;
            end else begin
                i_pop <= 1'b1;
                if (!calm && $urandom_range(0, 2) == 0) stall = rand_gap();
            end
            if (mode_left == 0) begin
                calm = ($urandom_range(0, 4) == 0);
                mode_left = $urandom_range(20, 200);
            end else begin
                mode_left--;
            end
        end
    end

    // sample at the rising edge, compare at the following falling edge
    logic    took = 1'b0;
    t_result took_res = '0;

    always @(posedge i_clk) begin
        took <= i_rst_n && i_pop && !o_empty;
        took_res <= {o_payload_byte, o_last, o_empty_frame};
    end

    always @(negedge i_clk) begin
        if (took) begin
            t_result want;
            if (due_results.size() == 0) begin
                $display("%0t: unexpected word payload_byte=%h last=%b empty_frame=%b",
                         $time, took_res.payload_byte, took_res.last, took_res.empty_frame);
                mismatches++;
            end else begin
                want = due_results.pop_front();
                if (took_res.payload_byte !== want.payload_byte) begin
                    $display("%0t: payload_byte expected %h actual %h",
                             $time, want.payload_byte, took_res.payload_byte);
                    mismatches++;
                end
                if (took_res.last !== want.last) begin
                    $display("%0t: last expected %b actual %b", $time, want.last, took_res.last);
                    mismatches++;
                end
                if (took_res.empty_frame !== want.empty_frame) begin
                    $display("%0t: empty_frame expected %b actual %b",
                             $time, want.empty_frame, took_res.empty_frame);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        logic             has;
        t_result          r;
        logic [ByteW-1:0] cfg_start [6];
        logic [ByteW-1:0] cfg_esc [6];
        int               goal;

        cfg_start = '{StartReset, 8'h00, 8'hFF, 8'h5A, 8'($urandom), 8'($urandom)};
        cfg_esc = '{EscapeReset, 8'hFF, 8'h00, 8'h5A, 8'($urandom), 8'($urandom)};

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < DirRows; k++) begin
            offer(dir_tab[k].rx);
            deframe_byte(dir_tab[k].rx, has, r);
            if (dir_tab[k].typed) begin
                if (dir_tab[k].has_res) due_results.push_back(dir_tab[k].res);
            end else if (has) begin
                due_results.push_back(r);
            end
            idle_gap();
        end
        settle();

        for (int p = 0; p < 6; p++) begin
            if (p > 0) begin
                if ($urandom_range(0, 1) == 0) begin
                    write_reg(CfgStart, cfg_start[p]);
                    write_reg(CfgEscape, cfg_esc[p]);
                end else begin
                    write_reg(CfgEscape, cfg_esc[p]);
                    write_reg(CfgStart, cfg_start[p]);
                end
            end
            goal = frame_words + PhaseWords;
            while (frame_words < goal) begin
                if ($urandom_range(0, 5) == 0) send_noise();
                else send_frame();
            end
            settle();
        end

        if (mismatches == 0 && due_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
